// File: hdl/lbc_pkg.sv
// Package for the stereo lo-fi bitcrusher: datapath widths, fixed coefficients,
// register indexes, sequencer states and the saturation helper.
// No dependencies.
package lbc_pkg;

  // Accumulator, multiplier operand and rounded-accumulator widths
  localparam int ACC_W = 56;
  localparam int RND_W = ACC_W - 16;
  localparam int A_W   = 35;
  localparam int B_W   = 18;

  // Internal signal is Q7.24
  localparam int FRAC = 24;

  // Configuration channel widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  // Pink noise pole and feed coefficients (Q0.16 / Q1.16)
  localparam logic signed [B_W-1:0] C_POLE_A = 18'sd65382;
  localparam logic signed [B_W-1:0] C_FEED_A = 18'sd6491;
  localparam logic signed [B_W-1:0] C_POLE_B = 18'sd63111;
  localparam logic signed [B_W-1:0] C_FEED_B = 18'sd19432;
  localparam logic signed [B_W-1:0] C_POLE_C = 18'sd37356;
  localparam logic signed [B_W-1:0] C_FEED_C = 18'sd68989;
  localparam logic signed [B_W-1:0] C_FEED_D = 18'sd12111;
  localparam logic signed [B_W-1:0] C_PINK   = 18'sd7209;
  localparam logic signed [B_W-1:0] C_DUST   = 18'sd6554;
  localparam logic signed [B_W-1:0] C_UNITY  = 18'sd1;

  // Crackle trigger thresholds (draw must be strictly above)
  localparam logic [15:0] POP_LIMIT  = 16'd65522;
  localparam logic [15:0] DUST_LIMIT = 16'd65208;

  // Full wet mix
  localparam logic [16:0] MIX_ONE = 17'h10000;

  // Low-pass output clamp, +-1.0 in Q7.24
  localparam logic signed [31:0] LP_CLAMP = 32'sd16777216;

  // Register reset values
  localparam logic [4:0]  RST_BIT_DEPTH     = 5'd16;
  localparam logic [6:0]  RST_HOLD_PERIOD   = 7'd1;
  localparam logic [15:0] RST_LOWPASS_ALPHA = 16'd47417;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIT_DEPTH,
    CFG_HOLD_PERIOD,
    CFG_NOISE_GAIN,
    CFG_CRACKLE_GAIN,
    CFG_LOWPASS_ALPHA,
    CFG_WET_MIX
  } cfg_reg_t;

  // Accumulator base for the next multiply-accumulate
  typedef enum logic [1:0] {
    BASE_ZERO,
    BASE_ACC,
    BASE_RND
  } base_t;

  typedef struct packed {
    logic  en;
    base_t base;
  } mac_ctrl_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PA0,
    ST_PA1,
    ST_PB0,
    ST_PB1,
    ST_PC0,
    ST_PC1,
    ST_WD,
    ST_SA,
    ST_SB,
    ST_SC,
    ST_PINK,
    ST_NOISE,
    ST_DUST,
    ST_POP,
    ST_CRK,
    ST_NSUM,
    ST_WET,
    ST_LP0,
    ST_LP1,
    ST_MIX0,
    ST_MIX1,
    ST_RES,
    ST_DONE
  } state_t;

  // Saturate a wide signed value to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-32){1'b0}}, 32'h7FFF_FFFF};
    lo = {{(ACC_W-32){1'b1}}, 32'h8000_0000};
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

// File: hdl/lbc_frame_if.sv
// Input frame channel: stereo dry samples plus the random draws for one frame.
// Depends on nothing; SAMPLE_WIDTH sets the signed sample field widths.
interface lbc_frame_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_in;
  logic signed [SAMPLE_WIDTH-1:0] right_in;
  logic signed [SAMPLE_WIDTH-1:0] white_noise;
  logic        [15:0]             pop_draw;
  logic signed [SAMPLE_WIDTH-1:0] pop_noise;
  logic        [15:0]             dust_draw;
  logic signed [SAMPLE_WIDTH-1:0] dust_noise;

  modport source (
    output valid, left_in, right_in, white_noise, pop_draw, pop_noise, dust_draw,
           dust_noise,
    input  ready
  );

  modport sink (
    input  valid, left_in, right_in, white_noise, pop_draw, pop_noise, dust_draw,
           dust_noise,
    output ready
  );
endinterface

// File: hdl/lbc_result_if.sv
// Output frame channel: processed stereo samples.
// Depends on nothing; SAMPLE_WIDTH sets the sample field widths.
interface lbc_result_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_out;
  logic signed [SAMPLE_WIDTH-1:0] right_out;

  modport source (
    output valid, left_out, right_out,
    input  ready
  );

  modport sink (
    input  valid, left_out, right_out,
    output ready
  );
endinterface

// File: hdl/lbc_cfg_if.sv
// Configuration write channel: register index and write data.
// Uses widths from lbc_pkg.
interface lbc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lbc_pkg::CFG_IDX_W-1:0]  index;
  logic [lbc_pkg::CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// File: hdl/lbc_mac.sv
// Shared multiply-accumulate unit with a registered accumulator and a
// round-half-up view of the accumulator scaled down by 2^16. Uses lbc_pkg.
module lbc_mac (
  input  logic                               clk,
  input  lbc_pkg::mac_ctrl_t                 ctrl,
  input  logic signed [lbc_pkg::A_W-1:0]     a,
  input  logic signed [lbc_pkg::B_W-1:0]     b,
  output logic signed [lbc_pkg::ACC_W-1:0]   acc,
  output logic signed [lbc_pkg::RND_W-1:0]   rnd
);

  localparam int P_W = lbc_pkg::A_W + lbc_pkg::B_W;
  localparam logic signed [lbc_pkg::ACC_W-1:0] HALF = lbc_pkg::ACC_W'(32768);

  logic signed [P_W-1:0]            prod;
  logic signed [lbc_pkg::ACC_W-1:0] base;
  logic signed [lbc_pkg::ACC_W-1:0] acc_half;

  assign prod = a * b;

  // Accumulator base select
  always_comb begin
    case (ctrl.base)
      lbc_pkg::BASE_ACC: base = acc;
      lbc_pkg::BASE_RND: base = {{16{rnd[lbc_pkg::RND_W-1]}}, rnd};
      default:           base = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc <= base + {{(lbc_pkg::ACC_W-P_W){prod[P_W-1]}}, prod};
    end
  end

  // Add half an LSB, floor shift by 16
  assign acc_half = acc + HALF;
  assign rnd      = acc_half[lbc_pkg::ACC_W-1:16];

endmodule

// File: hdl/lbc_quant.sv
// Bit-depth quantizer: round half away from zero to bit_depth bits, clamp to
// +-1.0, bypass at full width. Combinational; no package dependency.
module lbc_quant #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic signed [SAMPLE_WIDTH-1:0] x,
  input  logic        [4:0]              bit_depth,
  output logic signed [SAMPLE_WIDTH:0]   q
);

  localparam int SH_W = $clog2(SAMPLE_WIDTH);
  localparam logic [SAMPLE_WIDTH:0] ONE = (SAMPLE_WIDTH+1)'(1) << (SAMPLE_WIDTH-1);

  logic [4:0]            bits;
  logic                  bypass;
  logic [4:0]            shift_full;
  logic [SH_W-1:0]       shift;
  logic [SAMPLE_WIDTH-1:0] mag;
  logic [SAMPLE_WIDTH:0] half;
  logic [SAMPLE_WIDTH:0] mask;
  logic [SAMPLE_WIDTH:0] qm_raw;
  logic [SAMPLE_WIDTH:0] qm;

  // Depth zero acts as one bit
  assign bits       = (bit_depth == 5'd0) ? 5'd1 : bit_depth;
  assign bypass     = bits >= 5'(SAMPLE_WIDTH);
  assign shift_full = 5'(SAMPLE_WIDTH) - bits;
  assign shift      = shift_full[SH_W-1:0];

  // Magnitude, rounding offset and truncation mask
  assign mag    = x[SAMPLE_WIDTH-1] ? (~x + 1'b1) : x;
  assign half   = (SAMPLE_WIDTH+1)'(1) << (shift - 1'b1);
  assign mask   = ~(((SAMPLE_WIDTH+1)'(1) << shift) - 1'b1);
  assign qm_raw = ({1'b0, mag} + half) & mask;
  assign qm     = (qm_raw > ONE) ? ONE : qm_raw;

  always_comb begin
    if (bypass) begin
      q = {x[SAMPLE_WIDTH-1], x};
    end else if (x[SAMPLE_WIDTH-1]) begin
      q = -$signed(qm);
    end else begin
      q = $signed(qm);
    end
  end

endmodule

// File: hdl/lofi_bitcrusher_stereo.sv
// Stereo lo-fi bitcrusher top level: sequencer, state and datapath registers
// around one shared multiply-accumulate unit. Uses lbc_pkg, lbc_mac, lbc_quant
// and the lbc_frame_if, lbc_result_if and lbc_cfg_if interfaces.
//
//   channel   direction  payload                                   transaction when
//   samples   in         left_in right_in white_noise pop_draw      valid && ready
//                        pop_noise dust_draw dust_noise
//   results   out        left_out right_out                        valid && ready
//   cfg       in         index data                                valid && ready
//
// Every product goes through the single multiply-accumulate unit, and the
// sequencer walks the pink-noise, crackle and per-channel low-pass and mix
// steps in order; samples is not ready again until the frame has left the
// final step.
// Reset (rst, synchronous) restores register defaults and clears all filter,
// hold and output-valid state. cfg is always ready.
// A result waiting on results.ready holds the block in its final step; samples
// is ready only while the sequencer is idle.
module lofi_bitcrusher_stereo #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int CHANNEL_COUNT = 2
) (
  input logic            clk,
  input logic            rst,
  lbc_frame_if.sink      samples,
  lbc_result_if.source   results,
  lbc_cfg_if.sink        cfg
);

  localparam int A_W   = lbc_pkg::A_W;
  localparam int B_W   = lbc_pkg::B_W;
  localparam int ACC_W = lbc_pkg::ACC_W;
  localparam int RND_W = lbc_pkg::RND_W;
  localparam int SW    = SAMPLE_WIDTH;
  localparam int UP    = lbc_pkg::FRAC - (SAMPLE_WIDTH - 1);

  localparam logic signed [RND_W-1:0] OUT_HALF = RND_W'(1) << (UP - 1);
  localparam logic signed [RND_W-1:0] OUT_MAX  = RND_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [RND_W-1:0] OUT_MIN  = ~OUT_MAX;
  localparam logic                    LAST_CH  = 1'(CHANNEL_COUNT - 1);

  // Configuration registers
  logic [4:0]  bit_depth;
  logic [6:0]  hold_period;
  logic [15:0] noise_gain;
  logic [15:0] crackle_gain;
  logic [15:0] lowpass_alpha;
  logic [16:0] wet_mix;

  // Filter and hold state
  lbc_pkg::state_t          state;
  lbc_pkg::state_t          state_next;
  logic                     ch;
  logic                     out_valid;
  logic [6:0]               hold_count;
  logic signed [SW-1:0]     held [2];
  logic signed [31:0]       pole_a;
  logic signed [31:0]       pole_b;
  logic signed [31:0]       pole_c;
  logic signed [31:0]       lp [2];

  // Frame payload and working registers
  logic signed [SW-1:0]     dry [2];
  logic signed [SW-1:0]     white;
  logic signed [SW-1:0]     pop_amp;
  logic signed [SW-1:0]     dust_amp;
  logic                     pop_hit;
  logic                     dust_hit;
  logic signed [A_W-1:0]    nsum;
  logic signed [A_W-1:0]    wet;
  logic signed [SW-1:0]     res [2];
  logic signed [SW-1:0]     left_q;
  logic signed [SW-1:0]     right_q;

  // Shared unit hookup
  lbc_pkg::mac_ctrl_t       mac_ctrl;
  logic signed [A_W-1:0]    mac_a;
  logic signed [B_W-1:0]    mac_b;
  logic signed [ACC_W-1:0]  acc;
  logic signed [RND_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  rnd_ext;

  // Derived operands
  logic [6:0]               hold_inc;
  logic                     capture;
  logic [16:0]              mix_sat;
  logic [16:0]              mix_dry;
  logic signed [SW:0]       quant;
  logic signed [A_W-1:0]    w_op;
  logic signed [A_W-1:0]    pop_op;
  logic signed [A_W-1:0]    dust_op;
  logic signed [A_W-1:0]    dry_op;
  logic signed [31:0]       lp_clamped;
  logic signed [RND_W-1:0]  out_half;
  logic signed [RND_W-1:0]  out_shift;
  logic signed [SW-1:0]     out_val;
  logic                     accept;
  logic                     out_free;

  lbc_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .a    (mac_a),
    .b    (mac_b),
    .acc  (acc),
    .rnd  (rnd)
  );

  lbc_quant #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_quant (
    .x         (held[ch]),
    .bit_depth (bit_depth),
    .q         (quant)
  );

  assign accept   = samples.valid && samples.ready;
  assign out_free = !out_valid || results.ready;
  assign rnd_ext  = {{(ACC_W-RND_W){rnd[RND_W-1]}}, rnd};

  // Sample-and-hold counter
  assign hold_inc = hold_count + 7'd1;
  assign capture  = hold_inc >= hold_period;

  // Mix weights, overrange wet mix saturates to fully wet
  assign mix_sat = (wet_mix > lbc_pkg::MIX_ONE) ? lbc_pkg::MIX_ONE : wet_mix;
  assign mix_dry = lbc_pkg::MIX_ONE - mix_sat;

  // Sample-unit values lifted to Q7.24
  assign w_op    = A_W'(white) <<< UP;
  assign pop_op  = pop_hit  ? (A_W'(pop_amp) <<< (UP - 1)) : '0;
  assign dust_op = dust_hit ? (A_W'(dust_amp) <<< UP) : '0;
  assign dry_op  = A_W'(dry[ch]) <<< UP;

  // Low-pass level limited to +-1.0 before the mix
  always_comb begin
    if (lp[ch] > lbc_pkg::LP_CLAMP) begin
      lp_clamped = lbc_pkg::LP_CLAMP;
    end else if (lp[ch] < -lbc_pkg::LP_CLAMP) begin
      lp_clamped = -lbc_pkg::LP_CLAMP;
    end else begin
      lp_clamped = lp[ch];
    end
  end

  // Mix result back to sample units with rounding and saturation
  assign out_half  = rnd + OUT_HALF;
  assign out_shift = out_half >>> UP;
  always_comb begin
    if (out_shift > OUT_MAX) begin
      out_val = OUT_MAX[SW-1:0];
    end else if (out_shift < OUT_MIN) begin
      out_val = OUT_MIN[SW-1:0];
    end else begin
      out_val = out_shift[SW-1:0];
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and shared-unit operand selection
  always_comb begin
    state_next    = state;
    mac_ctrl.en   = 1'b0;
    mac_ctrl.base = lbc_pkg::BASE_ZERO;
    mac_a         = '0;
    mac_b         = '0;
    case (state)
      lbc_pkg::ST_IDLE: begin
        if (samples.valid) begin
          state_next = lbc_pkg::ST_PA0;
        end
      end
      lbc_pkg::ST_PA0: begin
        mac_ctrl.en = 1'b1;
        mac_a       = A_W'(pole_a);
        mac_b       = lbc_pkg::C_POLE_A;
        state_next  = lbc_pkg::ST_PA1;
      end
      lbc_pkg::ST_PA1: begin
        mac_ctrl    = '{en: 1'b1, base: lbc_pkg::BASE_ACC};
        mac_a       = w_op;
        mac_b       = lbc_pkg::C_FEED_A;
        state_next  = lbc_pkg::ST_PB0;
      end
      lbc_pkg::ST_PB0: begin
        mac_ctrl.en = 1'b1;
        mac_a       = A_W'(pole_b);
        mac_b       = lbc_pkg::C_POLE_B;
        state_next  = lbc_pkg::ST_PB1;
      end
      lbc_pkg::ST_PB1: begin
        mac_ctrl    = '{en: 1'b1, base: lbc_pkg::BASE_ACC};
        mac_a       = w_op;
        mac_b       = lbc_pkg::C_FEED_B;
        state_next  = lbc_pkg::ST_PC0;
      end
      lbc_pkg::ST_PC0: begin
        mac_ctrl.en = 1'b1;
        mac_a       = A_W'(pole_c);
        mac_b       = lbc_pkg::C_POLE_C;
        state_next  = lbc_pkg::ST_PC1;
      end
      lbc_pkg::ST_PC1: begin
        mac_ctrl    = '{en: 1'b1, base: lbc_pkg::BASE_ACC};
        mac_a       = w_op;
        mac_b       = lbc_pkg::C_FEED_C;
        state_next  = lbc_pkg::ST_WD;
      end
      lbc_pkg::ST_WD: begin
        mac_ctrl.en = 1'b1;
        mac_a       = w_op;
        mac_b       = lbc_pkg::C_FEED_D;
        state_next  = lbc_pkg::ST_SA;
      end
      // Sum of the three poles and the rounded direct term
      lbc_pkg::ST_SA: begin
        mac_ctrl    = '{en: 1'b1, base: lbc_pkg::BASE_RND};
        mac_a       = A_W'(pole_a);
        mac_b       = lbc_pkg::C_UNITY;
        state_next  = lbc_pkg::ST_SB;
      end
      lbc_pkg::ST_SB: begin
        mac_ctrl    = '{en: 1'b1, base: lbc_pkg::BASE_ACC};
        mac_a       = A_W'(pole_b);
        mac_b       = lbc_pkg::C_UNITY;
        state_next  = lbc_pkg::ST_SC;
      end
      lbc_pkg::ST_SC: begin
        mac_ctrl    = '{en: 1'b1, base: lbc_pkg::BASE_ACC};
        mac_a       = A_W'(pole_c);
        mac_b       = lbc_pkg::C_UNITY;
        state_next  = lbc_pkg::ST_PINK;
      end
      lbc_pkg::ST_PINK: begin
        mac_ctrl.en = 1'b1;
        mac_a       = acc[A_W-1:0];
        mac_b       = lbc_pkg::C_PINK;
        state_next  = lbc_pkg::ST_NOISE;
      end
      lbc_pkg::ST_NOISE: begin
        mac_ctrl.en = 1'b1;
        mac_a       = rnd[A_W-1:0];
        mac_b       = $signed({2'b00, noise_gain});
        state_next  = lbc_pkg::ST_DUST;
      end
      lbc_pkg::ST_DUST: begin
        mac_ctrl.en = 1'b1;
        mac_a       = dust_op;
        mac_b       = lbc_pkg::C_DUST;
        state_next  = lbc_pkg::ST_POP;
      end
      lbc_pkg::ST_POP: begin
        mac_ctrl    = '{en: 1'b1, base: lbc_pkg::BASE_RND};
        mac_a       = pop_op;
        mac_b       = lbc_pkg::C_UNITY;
        state_next  = lbc_pkg::ST_CRK;
      end
      lbc_pkg::ST_CRK: begin
        mac_ctrl.en = 1'b1;
        mac_a       = acc[A_W-1:0];
        mac_b       = $signed({2'b00, crackle_gain});
        state_next  = lbc_pkg::ST_NSUM;
      end
      lbc_pkg::ST_NSUM: begin
        state_next  = lbc_pkg::ST_WET;
      end
      // Per-channel steps
      lbc_pkg::ST_WET: begin
        state_next  = lbc_pkg::ST_LP0;
      end
      lbc_pkg::ST_LP0: begin
        mac_ctrl.en = 1'b1;
        mac_a       = wet - A_W'(lp[ch]);
        mac_b       = $signed({2'b00, lowpass_alpha});
        state_next  = lbc_pkg::ST_LP1;
      end
      lbc_pkg::ST_LP1: begin
        mac_ctrl    = '{en: 1'b1, base: lbc_pkg::BASE_RND};
        mac_a       = A_W'(lp[ch]);
        mac_b       = lbc_pkg::C_UNITY;
        state_next  = lbc_pkg::ST_MIX0;
      end
      lbc_pkg::ST_MIX0: begin
        mac_ctrl.en = 1'b1;
        mac_a       = dry_op;
        mac_b       = $signed({1'b0, mix_dry});
        state_next  = lbc_pkg::ST_MIX1;
      end
      lbc_pkg::ST_MIX1: begin
        mac_ctrl    = '{en: 1'b1, base: lbc_pkg::BASE_ACC};
        mac_a       = A_W'(lp_clamped);
        mac_b       = $signed({1'b0, mix_sat});
        state_next  = lbc_pkg::ST_RES;
      end
      lbc_pkg::ST_RES: begin
        state_next = (ch == LAST_CH) ? lbc_pkg::ST_DONE : lbc_pkg::ST_WET;
      end
      lbc_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = lbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lbc_pkg::ST_IDLE;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_depth     <= lbc_pkg::RST_BIT_DEPTH;
      hold_period   <= lbc_pkg::RST_HOLD_PERIOD;
      noise_gain    <= '0;
      crackle_gain  <= '0;
      lowpass_alpha <= lbc_pkg::RST_LOWPASS_ALPHA;
      wet_mix       <= lbc_pkg::MIX_ONE;
    end else if (cfg.valid) begin
      case (cfg.index)
        lbc_pkg::CFG_BIT_DEPTH:     bit_depth     <= cfg.data[4:0];
        lbc_pkg::CFG_HOLD_PERIOD:   hold_period   <= cfg.data[6:0];
        lbc_pkg::CFG_NOISE_GAIN:    noise_gain    <= cfg.data[15:0];
        lbc_pkg::CFG_CRACKLE_GAIN:  crackle_gain  <= cfg.data[15:0];
        lbc_pkg::CFG_LOWPASS_ALPHA: lowpass_alpha <= cfg.data[15:0];
        lbc_pkg::CFG_WET_MIX:       wet_mix       <= cfg.data;
        default: ;
      endcase
    end
  end

  // Hold, filter state, channel pointer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ch         <= 1'b0;
      out_valid  <= 1'b0;
      hold_count <= '0;
      held[0]    <= '0;
      held[1]    <= '0;
      pole_a     <= '0;
      pole_b     <= '0;
      pole_c     <= '0;
      lp[0]      <= '0;
      lp[1]      <= '0;
    end else begin
      case (state)
        lbc_pkg::ST_IDLE: begin
          if (accept) begin
            hold_count <= capture ? 7'd0 : hold_inc;
            if (capture) begin
              held[0] <= samples.left_in;
              held[1] <= samples.right_in;
            end
          end
        end
        lbc_pkg::ST_PB0:  pole_a <= lbc_pkg::sat32(rnd_ext);
        lbc_pkg::ST_PC0:  pole_b <= lbc_pkg::sat32(rnd_ext);
        lbc_pkg::ST_WD:   pole_c <= lbc_pkg::sat32(rnd_ext);
        lbc_pkg::ST_NSUM: ch <= 1'b0;
        lbc_pkg::ST_MIX0: lp[ch] <= lbc_pkg::sat32(acc);
        lbc_pkg::ST_RES:  ch <= ch + 1'b1;
        default: ;
      endcase
      if (state == lbc_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Frame payload, noise sum, wet value and results
  always_ff @(posedge clk) begin
    case (state)
      lbc_pkg::ST_IDLE: begin
        if (accept) begin
          dry[0]   <= samples.left_in;
          dry[1]   <= samples.right_in;
          white    <= samples.white_noise;
          pop_amp  <= samples.pop_noise;
          dust_amp <= samples.dust_noise;
          pop_hit  <= samples.pop_draw > lbc_pkg::POP_LIMIT;
          dust_hit <= samples.dust_draw > lbc_pkg::DUST_LIMIT;
        end
      end
      lbc_pkg::ST_DUST: nsum <= rnd[A_W-1:0];
      lbc_pkg::ST_NSUM: nsum <= nsum + rnd[A_W-1:0];
      lbc_pkg::ST_WET:  wet  <= (A_W'(quant) <<< UP) + nsum;
      lbc_pkg::ST_RES:  res[ch] <= out_val;
      lbc_pkg::ST_DONE: begin
        if (out_free) begin
          left_q  <= res[0];
          right_q <= (CHANNEL_COUNT > 1) ? res[1] : '0;
        end
      end
      default: ;
    endcase
  end

  // Channel handshakes
  assign samples.ready     = (state == lbc_pkg::ST_IDLE);
  assign cfg.ready         = 1'b1;
  assign results.valid     = out_valid;
  assign results.left_out  = left_q;
  assign results.right_out = right_q;

endmodule

// File: sim/lbc_tb_pkg.sv
// Test-side package for the stereo lo-fi bitcrusher: frame types and a scoreboard class
// that predicts every processed frame and checks the block's output against it.
// Depends on lbc_pkg for the register index codes and crackle thresholds.
`timescale 1ns / 100ps
package lbc_tb_pkg;
  import lbc_pkg::*;

  localparam int SMP_W    = 16;
  localparam int SHIFT_UP = FRAC - (SMP_W - 1);

  // One input frame: dry samples plus the random draws
  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic signed [15:0] white;
    logic        [15:0] pop_draw;
    logic signed [15:0] pop_noise;
    logic        [15:0] dust_draw;
    logic signed [15:0] dust_noise;
  } frame_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } stereo_t;

  // Round half up, then floor shift
  function automatic longint rnd_shift(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  class crush_scoreboard;
    // Register shadows
    logic [4:0]  depth;
    logic [6:0]  period;
    logic [15:0] ngain;
    logic [15:0] cgain;
    logic [15:0] alpha;
    logic [16:0] mix_reg;
    // Filter and hold state
    int          held[2];
    logic [6:0]  hold_cnt;
    int          pole_a;
    int          pole_b;
    int          pole_c;
    int          lp_level[2];

    stereo_t     pending_out[$];
    int          errors;
    int          results_seen;

    function new();
      depth       = 5'd16;
      period      = 7'd1;
      ngain       = 16'd0;
      cgain       = 16'd0;
      alpha       = 16'd47417;
      mix_reg     = 17'd65536;
      held[0]     = 0;
      held[1]     = 0;
      hold_cnt    = 7'd0;
      pole_a      = 0;
      pole_b      = 0;
      pole_c      = 0;
      lp_level[0] = 0;
      lp_level[1] = 0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [16:0] data);
      case (idx)
        CFG_BIT_DEPTH:     depth   = data[4:0];
        CFG_HOLD_PERIOD:   period  = data[6:0];
        CFG_NOISE_GAIN:    ngain   = data[15:0];
        CFG_CRACKLE_GAIN:  cgain   = data[15:0];
        CFG_LOWPASS_ALPHA: alpha   = data[15:0];
        CFG_WET_MIX:       mix_reg = data;
        default: ;
      endcase
    endfunction

    // Round half away from zero to the configured depth; +1.0 is kept
    function longint quantize(longint x);
      int     bits;
      int     s;
      longint mag;
      longint q;
      bits = (depth < 5'd1) ? 1 : int'(depth);
      if (bits >= SMP_W) return x;
      s   = SMP_W - bits;
      mag = (x < 0) ? -x : x;
      q   = ((mag + (longint'(1) <<< (s - 1))) >>> s) <<< s;
      if (x < 0) q = -q;
      if (q > 64'sd32768) q = 64'sd32768;
      if (q < -64'sd32768) q = -64'sd32768;
      return q;
    endfunction

    // Advance the prediction by one accepted frame and queue its output
    function void note_frame(frame_t f);
      longint  w;
      longint  sum;
      longint  pink;
      longint  noise;
      longint  crk;
      longint  mix;
      longint  dry;
      longint  wet;
      longint  lp;
      longint  o;
      bit      capture;
      stereo_t res;
      logic signed [15:0] outs[2];

      // Pink noise from three poles plus a direct tap
      w      = longint'($signed(f.white)) <<< SHIFT_UP;
      pole_a = int'(clip32(rnd_shift(65382 * longint'(pole_a) + 6491 * w, 16)));
      pole_b = int'(clip32(rnd_shift(63111 * longint'(pole_b) + 19432 * w, 16)));
      pole_c = int'(clip32(rnd_shift(37356 * longint'(pole_c) + 68989 * w, 16)));
      sum    = longint'(pole_a) + longint'(pole_b) + longint'(pole_c)
             + rnd_shift(12111 * w, 16);
      pink   = rnd_shift(sum * 7209, 16);
      noise  = rnd_shift(pink * longint'(ngain), 16);

      // Crackle: pop halves the noise by floor, dust scales by 0.1
      crk = 0;
      if (f.pop_draw > POP_LIMIT)
        crk = (longint'($signed(f.pop_noise)) <<< SHIFT_UP) >>> 1;
      if (f.dust_draw > DUST_LIMIT)
        crk += rnd_shift((longint'($signed(f.dust_noise)) <<< SHIFT_UP) * 6554, 16);
      crk = rnd_shift(crk * longint'(cgain), 16);

      // Sample-and-hold timing
      hold_cnt = hold_cnt + 7'd1;
      capture  = (hold_cnt >= period);
      if (capture) hold_cnt = 7'd0;

      mix = (mix_reg > 17'd65536) ? 64'sd65536 : longint'(mix_reg);

      for (int ch = 0; ch < 2; ch++) begin
        dry = (ch == 0) ? longint'($signed(f.left)) : longint'($signed(f.right));
        if (capture) held[ch] = int'(dry);
        wet = quantize(longint'(held[ch])) <<< SHIFT_UP;
        wet = wet + noise + crk;
        lp  = longint'(lp_level[ch]);
        lp  = clip32(lp + rnd_shift(longint'(alpha) * (wet - lp), 16));
        lp_level[ch] = int'(lp);
        wet = lp;
        if (wet > 64'sd16777216) wet = 64'sd16777216;
        if (wet < -64'sd16777216) wet = -64'sd16777216;
        o = rnd_shift((dry <<< SHIFT_UP) * (65536 - mix) + wet * mix, 16);
        o = rnd_shift(o, SHIFT_UP);
        if (o > 64'sd32767) o = 64'sd32767;
        if (o < -64'sd32768) o = -64'sd32768;
        outs[ch] = o[15:0];
      end
      res.left  = outs[0];
      res.right = outs[1];
      pending_out.push_back(res);
    endfunction

    // Compare one output transaction with the oldest prediction
    function void check_result(logic signed [15:0] l, logic signed [15:0] r);
      stereo_t exp_out;
      results_seen++;
      if (pending_out.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Output %0d with no frame pending: L=%0d R=%0d", results_seen, l, r);
        return;
      end
      exp_out = pending_out.pop_front();
      if (exp_out.left !== l || exp_out.right !== r) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch on output %0d: expected L=%0d R=%0d, got L=%0d R=%0d",
                   results_seen, exp_out.left, exp_out.right, l, r);
      end
    endfunction

    function int pending();
      return pending_out.size();
    endfunction

    // Predictions never matched by an output count as failures
    function void close_out();
      if (pending_out.size() != 0) begin
        errors += pending_out.size();
        $display("%0d predicted outputs never arrived", pending_out.size());
      end
    endfunction
  endclass

endpackage

// File: sim/lofi_bitcrusher_stereo_tb.sv
// Top-level testbench for lofi_bitcrusher_stereo: directed and random frames with
// random handshake gaps and register changes between phases, checked by scoreboard.
// Depends on lbc_pkg, lbc_tb_pkg and the frame, result and cfg interfaces.
`timescale 1ns / 100ps
module lofi_bitcrusher_stereo_tb;
  import lbc_pkg::*;
  import lbc_tb_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int LONG_HOLD    = 400;
  localparam int RAND_PHASES  = 14;
  localparam int PHASE_FRAMES = 50;

  logic clk;
  logic rst;

  lbc_frame_if  #(.SAMPLE_WIDTH(16)) frm_if ();
  lbc_result_if #(.SAMPLE_WIDTH(16)) res_if ();
  lbc_cfg_if                         cfg_if ();

  lofi_bitcrusher_stereo #(
    .SAMPLE_WIDTH  (16),
    .CHANNEL_COUNT (2)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (frm_if),
    .results (res_if),
    .cfg     (cfg_if)
  );

  crush_scoreboard sb;
  bit              no_idle;
  bit              long_hold_req;
  int              idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: ends the run when no transaction happens for too long
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((frm_if.valid && frm_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Output side: random ready gaps, an occasional long hold-off
  initial begin : result_sink
    int gap;
    res_if.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!(res_if.valid && res_if.ready));
      sb.check_result(res_if.left_out, res_if.right_out);
    end
  end

  function automatic frame_t mk(int l, int r, int w, int pd, int pn, int dd, int dn);
    frame_t f;
    f.left       = l[15:0];
    f.right      = r[15:0];
    f.white      = w[15:0];
    f.pop_draw   = pd[15:0];
    f.pop_noise  = pn[15:0];
    f.dust_draw  = dd[15:0];
    f.dust_noise = dn[15:0];
    return f;
  endfunction

  // Mostly uniform, sometimes a full-scale or near-zero value
  function automatic logic [15:0] rand_sample();
    logic [15:0] v;
    case ($urandom_range(0, 11))
      0:       v = 16'h8000;
      1:       v = 16'h7FFF;
      2:       v = 16'h0000;
      3:       v = 16'hFFFF;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Draws are biased toward the pop and dust thresholds
  function automatic frame_t rand_frame();
    frame_t f;
    f.left       = rand_sample();
    f.right      = rand_sample();
    f.white      = rand_sample();
    f.pop_draw   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(65500, 65535))
                                               : 16'($urandom());
    f.pop_noise  = rand_sample();
    f.dust_draw  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(65150, 65535))
                                               : 16'($urandom());
    f.dust_noise = rand_sample();
    return f;
  endfunction

  task automatic send_frame(input frame_t f);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      frm_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frm_if.left_in     <= f.left;
    frm_if.right_in    <= f.right;
    frm_if.white_noise <= f.white;
    frm_if.pop_draw    <= f.pop_draw;
    frm_if.pop_noise   <= f.pop_noise;
    frm_if.dust_draw   <= f.dust_draw;
    frm_if.dust_noise  <= f.dust_noise;
    frm_if.valid       <= 1'b1;
    do @(posedge clk); while (!frm_if.ready);
    sb.note_frame(f);
  endtask

  // Stop offering frames and wait until every prediction is matched
  task automatic drain();
    frm_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [16:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_config(input logic [16:0] dep, input logic [16:0] per,
                              input logic [16:0] ng, input logic [16:0] cg,
                              input logic [16:0] alp, input logic [16:0] mx);
    cfg_write(CFG_BIT_DEPTH, dep);
    cfg_write(CFG_HOLD_PERIOD, per);
    cfg_write(CFG_NOISE_GAIN, ng);
    cfg_write(CFG_CRACKLE_GAIN, cg);
    cfg_write(CFG_LOWPASS_ALPHA, alp);
    cfg_write(CFG_WET_MIX, mx);
    cfg_if.valid <= 1'b0;
  endtask

  // Random register set with the extremes drawn often
  task automatic random_config();
    logic [16:0] dep;
    logic [16:0] per;
    logic [16:0] ng;
    logic [16:0] cg;
    logic [16:0] alp;
    logic [16:0] mx;
    case ($urandom_range(0, 6))
      0:       dep = 17'd0;
      1:       dep = 17'd1;
      2:       dep = 17'd16;
      3:       dep = 17'd31;
      default: dep = $urandom_range(1, 17);
    endcase
    case ($urandom_range(0, 7))
      0:       per = 17'd0;
      1:       per = 17'd127;
      2:       per = $urandom_range(0, 127);
      default: per = $urandom_range(1, 6);
    endcase
    case ($urandom_range(0, 3))
      0:       ng = 17'd0;
      1:       ng = 17'd65535;
      default: ng = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 3))
      0:       cg = 17'd0;
      1:       cg = 17'd65535;
      default: cg = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 3))
      0:       alp = 17'd0;
      1:       alp = 17'd65535;
      default: alp = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 5))
      0:       mx = 17'd0;
      1:       mx = 17'd65536;
      2:       mx = $urandom_range(65537, 131071);
      default: mx = $urandom_range(0, 65536);
    endcase
    apply_config(dep, per, ng, cg, alp, mx);
  endtask

  initial begin : main
    sb            = new();
    no_idle       = 1'b0;
    long_hold_req = 1'b0;
    rst                <= 1'b1;
    frm_if.valid       <= 1'b0;
    frm_if.left_in     <= '0;
    frm_if.right_in    <= '0;
    frm_if.white_noise <= '0;
    frm_if.pop_draw    <= '0;
    frm_if.pop_noise   <= '0;
    frm_if.dust_draw   <= '0;
    frm_if.dust_noise  <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= CFG_BIT_DEPTH;
    cfg_if.data        <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults: field extremes
    send_frame(mk(32767, -32768, 0, 0, 0, 0, 0));
    send_frame(mk(-32768, 32767, 32767, 65535, 32767, 65535, 32767));
    send_frame(mk(0, 0, -32768, 65522, -32768, 65208, -32768));
    send_frame(mk(-1, 1, -1, 65523, 1, 65209, -1));
    drain();

    // One-bit depth with full-scale input rounds to +1.0; zero period; excess mix
    apply_config(17'd1, 17'd0, 17'd65535, 17'd65535, 17'd65535, 17'd131071);
    send_frame(mk(32767, -32768, 32767, 65523, 32767, 65209, 32767));
    send_frame(mk(16384, -16384, -32768, 65522, -32768, 65208, -32768));
    send_frame(mk(-16385, 16383, 0, 65535, -32768, 65535, -32768));
    send_frame(mk(0, 0, 0, 65523, 0, 0, 0));
    send_frame(mk(1, -1, 12345, 0, 0, 65209, 32767));
    drain();

    // Zero depth acts as one bit; longest hold; fully dry; frozen low-pass
    apply_config(17'd0, 17'd127, 17'd0, 17'd32768, 17'd0, 17'd0);
    send_frame(mk(24576, -24575, 32767, 65535, 32767, 65535, 32767));
    send_frame(mk(-32768, 32767, -32768, 65523, -32768, 65209, -32768));
    send_frame(mk(100, -100, 0, 0, 0, 0, 0));
    send_frame(mk(-8192, 8191, 1, 1, 1, 1, 1));
    drain();

    // Depth above the sample width bypasses; period of three; half mix
    apply_config(17'd31, 17'd3, 17'd40000, 17'd65535, 17'd47417, 17'd32768);
    send_frame(mk(30000, -30000, 20000, 65535, 20000, 0, 0));
    send_frame(mk(-5, 5, -20000, 0, 0, 65535, -20000));
    send_frame(mk(7, -7, 32767, 0, 0, 0, 0));
    send_frame(mk(-32768, 32767, -32768, 65523, -32768, 65209, 32767));
    send_frame(mk(12, -12, 0, 0, 0, 0, 0));
    send_frame(mk(0, 0, 0, 0, 0, 0, 0));
    drain();

    // Fifteen bits; period two; mix just past full wet
    apply_config(17'd15, 17'd2, 17'd65535, 17'd0, 17'd65535, 17'd65537);
    send_frame(mk(32767, -32768, 32767, 65535, 32767, 65535, 32767));
    send_frame(mk(-3, 3, -32768, 0, 0, 0, 0));
    send_frame(mk(32765, -32767, 0, 0, 0, 0, 0));
    send_frame(mk(1, -2, 5, 0, 0, 0, 0));
    drain();

    // Random phases, each with its own register set
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      random_config();
      no_idle = (ph % 5 == 2);
      if (ph == 3 || ph == 9) long_hold_req = 1'b1;
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        send_frame(rand_frame());
      end
      drain();
    end
    no_idle = 1'b0;

    repeat (40) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
